@@ src/pls_pkg.sv @@
// Shared constants, codes and control types for the positional list store.
`timescale 1ns / 1ps

package pls_pkg;

  localparam int DEPTH     = 16;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int COUNT_W   = 5;
  localparam int POS_W     = 5;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;
  localparam int S_TDATA_W = ((POS_W + DATA_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((DATA_W + COUNT_W + 7) / 8) * 8;

  localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(DEPTH);

  // Command kinds.
  localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic execute;  // apply the latched request and load the result register
  } pls_cmd_t;

endpackage

@@ src/pls_ctrl.sv @@
// Controller state machine: request intake, execute step and result valid.
`timescale 1ns / 1ps

module pls_ctrl
  import pls_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output pls_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic valid;
  logic valid_next;
  logic out_free;

  assign out_free = !valid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = valid;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The result register must be free, or be emptied this cycle.
        if (out_free) begin
          cmd.execute = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.execute) begin
      valid_next = 1'b1;
    end else if (m_tready) begin
      valid_next = 1'b0;
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= valid_next;
    end
  end

`ifndef SYNTHESIS
  a_valid_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.execute))
    else $error("result valid rose without an execute step");

  a_exec_once: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> !cmd.execute)
    else $error("request executed twice");
`endif

endmodule

@@ src/pls_datapath.sv @@
// Datapath: request latch, entry array with parallel shift, count and result register.
`timescale 1ns / 1ps

module pls_datapath
  import pls_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  pls_cmd_t                   cmd,
  input  logic [ACT_W-1:0]           in_action,
  input  logic [POS_W-1:0]           in_position,
  input  logic signed [DATA_W-1:0]   in_value,
  output logic [STAT_W-1:0]          out_status,
  output logic signed [DATA_W-1:0]   out_popped,
  output logic [COUNT_W-1:0]         out_count
);

  logic [ACT_W-1:0]         action;
  logic [POS_W-1:0]         position;
  logic [DATA_W-1:0]        value;
  logic [DATA_W-1:0]        entries [DEPTH];
  logic [DATA_W-1:0]        entries_next [DEPTH];
  logic [COUNT_W-1:0]       count;
  logic [COUNT_W-1:0]       count_next;
  logic [STAT_W-1:0]        status_next;
  logic [DATA_W-1:0]        popped_next;
  logic [COUNT_W-1:0]       count_m1;
  logic [COUNT_W-1:0]       ins_idx;
  logic                     full;

  assign full     = (count >= DEPTH_COUNT);
  assign count_m1 = count - COUNT_W'(1);
  assign ins_idx  = (position == '0) ? '0 : position - POS_W'(1);

  always_comb begin
    count_next  = count;
    status_next = STAT_DONE;
    popped_next = '0;
    for (int k = 0; k < DEPTH; k++) begin
      entries_next[k] = entries[k];
    end
    case (action)
      ACT_PUSH: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          for (int k = 0; k < DEPTH; k++) begin
            if (COUNT_W'(k) == count) entries_next[k] = value;
          end
          count_next = count + COUNT_W'(1);
        end
      end
      ACT_POP: begin
        if (count == '0) begin
          status_next = STAT_EMPTY;
          popped_next = '1;
        end else begin
          popped_next = entries[count_m1[IDX_W-1:0]];
          count_next  = count_m1;
        end
      end
      ACT_INSERT: begin
        if (position > count) begin
          status_next = STAT_RANGE;
        end else if (full) begin
          status_next = STAT_FULL;
        end else begin
          for (int k = 1; k < DEPTH; k++) begin
            if (COUNT_W'(k) > ins_idx && COUNT_W'(k) <= count) begin
              entries_next[k] = entries[k-1];
            end
          end
          for (int k = 0; k < DEPTH; k++) begin
            if (COUNT_W'(k) == ins_idx) entries_next[k] = value;
          end
          count_next = count + COUNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        if (position == '0 || position > count) begin
          status_next = STAT_RANGE;
        end else begin
          for (int k = 0; k < DEPTH - 1; k++) begin
            if (COUNT_W'(k) >= ins_idx && COUNT_W'(k + 1) < count) begin
              entries_next[k] = entries[k+1];
            end
          end
          count_next = count_m1;
        end
      end
      default: status_next = STAT_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action   <= in_action;
      position <= in_position;
      value    <= in_value;
    end
    if (cmd.execute) begin
      for (int k = 0; k < DEPTH; k++) begin
        entries[k] <= entries_next[k];
      end
      out_status <= status_next;
      out_popped <= popped_next;
      out_count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_COUNT)
    else $error("entry count above list depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(cmd.execute)) |-> $stable(count))
    else $error("entry count changed outside an execute step");
`endif

endmodule

@@ src/positional_list_store.sv @@
// Top level of the positional list store: stream ports, controller and datapath.
`timescale 1ns / 1ps
//
//  Channel  Direction  Carries
//  s_*      in         request: tuser = action, tdata = position, value
//  m_*      out        result:  tuser = status, tdata = popped, count
//
//  Each request is accepted and latched in the idle state, then applied to
//  the entry array, with the result register loaded, in the execute step.
//  Insert and remove shift all later entries by one place in that step.
//  A new request is accepted while the previous result still waits; the
//  execute step then holds until the result register is free.
//  Reset (rst, synchronous) empties the list; entry contents are not cleared.

module positional_list_store
  import pls_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // position[4:0], value[36:5], zero pad
  input  logic [ACT_W-1:0]     s_tuser,   // action[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // popped[31:0], count[36:32], zero pad
  output logic [STAT_W-1:0]    m_tuser    // status[1:0]
);

  pls_cmd_t                 cmd;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_popped;
  logic [COUNT_W-1:0]       out_count;

  // The controller sequences accept, execute and result delivery.
  pls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // The datapath holds the list and forms each result.
  pls_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_action   (s_tuser),
    .in_position (s_tdata[POS_W-1:0]),
    .in_value    (s_tdata[POS_W+DATA_W-1:POS_W]),
    .out_status  (out_status),
    .out_popped  (out_popped),
    .out_count   (out_count)
  );

  // Result fields are packed from the lowest bit up, padded to whole bytes.
  assign m_tdata = {{(M_TDATA_W - DATA_W - COUNT_W){1'b0}}, out_count, out_popped};
  assign m_tuser = out_status;

endmodule
